// ===== rtl/iirdf1_pkg.sv =====
package iirdf1_pkg;

  localparam int TAPS       = 4;
  localparam int NCOEF      = 2 * TAPS - 1;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 24;
  localparam int FRAC_SHIFT = 20;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(NCOEF) + 1;
  localparam int CNT_W      = $clog2(NCOEF + 1);
  localparam int IDX_W      = $clog2(NCOEF);
  localparam int XI_W       = $clog2(TAPS);
  localparam int YI_W       = (TAPS > 2) ? $clog2(TAPS - 1) : 1;
  localparam int ADDR_W     = $clog2(4 * NCOEF);
  localparam int DATA_W     = 32;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic clr;
    logic issue;
    logic sub;
  } mac_ctl_t;

endpackage

// ===== rtl/iirdf1_regs.sv =====
module iirdf1_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [iirdf1_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [iirdf1_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [iirdf1_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                           cfg_pready,
  input  logic [iirdf1_pkg::CNT_W-1:0]   rd_idx,
  output iirdf1_pkg::coef_t              rd_coef
);
  import iirdf1_pkg::*;

  coef_t             coef_r [NCOEF];
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_idx     = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= '0;
    end else if (wr_en && (wr_idx < IDX_W'(NCOEF))) begin
      coef_r[wr_idx] <= coef_t'(cfg_pwdata[COEF_W-1:0]);
    end
  end

  always_comb begin
    if (wr_idx < IDX_W'(NCOEF)) begin
      cfg_prdata = {{(DATA_W-COEF_W){coef_r[wr_idx][COEF_W-1]}}, coef_r[wr_idx]};
    end else begin
      cfg_prdata = '0;
    end
  end

  // coefficient feeding the shared multiplier
  always_comb begin
    if (rd_idx < CNT_W'(NCOEF)) begin
      rd_coef = coef_r[rd_idx[IDX_W-1:0]];
    end else begin
      rd_coef = '0;
    end
  end

endmodule

// ===== rtl/iirdf1_mac.sv =====
module iirdf1_mac (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iirdf1_pkg::mac_ctl_t  ctl,
  input  iirdf1_pkg::coef_t     coef,
  input  iirdf1_pkg::sample_t   data,
  output iirdf1_pkg::acc_t      acc
);
  import iirdf1_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     sub_r;
  acc_t                     acc_r;
  acc_t                     prod_ext;

  assign prod     = PROD_W'(coef) * PROD_W'(data);
  assign prod_ext = ACC_W'(prod_r);
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    sub_r  <= ctl.sub;
  end

  // accumulate one registered product per cycle; feedback terms subtract
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

endmodule

// ===== rtl/iir_direct_form_one_filter_core.sv =====
// Direct form I IIR filter, order three, one shared 24x16 multiply-accumulate.
// A new input beat is taken only in idle: the block issues the seven taps, drains the
// product register, rounds and saturates, then returns to idle; a finished result
// that waits on out_ready holds it in the round/saturate state. Reset (rst_n low,
// synchronous) clears coefficients and both histories to zero and empties the
// output register.
module iir_direct_form_one_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_filtered,
  output logic                           out_clipped,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [iirdf1_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [iirdf1_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [iirdf1_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import iirdf1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAC  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam acc_t    RND     = ACC_W'(1) << (FRAC_SHIFT - 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  sample_t           xh_r [TAPS];
  sample_t           yh_r [TAPS-1];
  sample_t           out_filtered_r;
  logic              out_clipped_r;
  logic              out_valid_r;

  mac_ctl_t          ctl;
  coef_t             mac_coef;
  sample_t           mac_data;
  acc_t              acc;
  acc_t              rnd;
  acc_t              shifted;
  logic [ACC_W-SAMPLE_W:0] hi;
  logic              clip;
  sample_t           y_sat;
  logic              accept;
  logic              fin_load;

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid & in_ready;
  assign fin_load     = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_clipped  = out_clipped_r;

  iirdf1_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .rd_idx      (cnt_r),
    .rd_coef     (mac_coef)
  );

  iirdf1_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .coef  (mac_coef),
    .data  (mac_data),
    .acc   (acc)
  );

  // tap order: inputs newest first, then previous outputs
  always_comb begin
    if (cnt_r < CNT_W'(TAPS)) begin
      mac_data = xh_r[cnt_r[XI_W-1:0]];
    end else if (cnt_r < CNT_W'(NCOEF)) begin
      mac_data = yh_r[YI_W'(cnt_r - CNT_W'(TAPS))];
    end else begin
      mac_data = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.clr   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        ctl.issue = (cnt_r < CNT_W'(NCOEF));
        ctl.sub   = (cnt_r >= CNT_W'(TAPS));
        cnt_nxt   = cnt_r + 1'b1;
        // last cycle only drains the product register
        if (cnt_r == CNT_W'(NCOEF)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // round half up, then saturate to 16 bits
  assign rnd     = acc + RND;
  assign shifted = rnd >>> FRAC_SHIFT;
  assign hi      = shifted[ACC_W-1:SAMPLE_W-1];
  assign clip    = !((&hi) || (~|hi));
  assign y_sat   = clip ? (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX)
                        : shifted[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) xh_r[i] <= '0;
      for (int i = 0; i < TAPS - 1; i++) yh_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (accept) begin
        for (int i = TAPS - 1; i > 0; i--) xh_r[i] <= xh_r[i-1];
        xh_r[0] <= in_sample_in;
      end
      if (fin_load) begin
        for (int i = TAPS - 2; i > 0; i--) yh_r[i] <= yh_r[i-1];
        yh_r[0]     <= y_sat;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_filtered_r <= y_sat;
      out_clipped_r  <= clip;
    end
  end

endmodule

// ===== rtl/iirdf1_chk.sv =====
module iirdf1_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [15:0]             out_filtered,
  input logic                           out_clipped,
  input logic                           cfg_psel,
  input logic                           cfg_pready
);
  import iirdf1_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered) && $stable(out_clipped))
    else $error("result beat changed while stalled");

  // an accepted sample keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting a beat");

  // a clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_filtered == 16'sh7fff || out_filtered == -16'sh8000)
    else $error("clipped result not at a saturation rail");

  // reset empties the output and leaves the input ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("configuration port inserted a wait state");

endmodule

bind iir_direct_form_one_filter_core iirdf1_chk u_iirdf1_chk (.*);
